// ===== design/servo_packet_deframer_assert.svh =====
// assertion macros for the servo packet deframer checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SERVO_PACKET_DEFRAMER_ASSERT_SVH
`define SERVO_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define SPD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("servo packet deframer check failed");

// next-cycle implication
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("servo packet deframer check failed");

`endif

// ===== design/spd_pkg.sv =====
// shared types and constants for the servo packet deframer
// no dependencies
`timescale 1ns / 1ps

package spd_pkg;

  localparam int WINDOW_BYTES   = 64;
  localparam int FRAME_OVERHEAD = 7;
  localparam int PTR_W  = $clog2(WINDOW_BYTES);
  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam int SUM_W  = ((FILL_W > 8) ? FILL_W : 8) + 1;
  localparam int IDX_W  = 6;
  localparam int ERR_W  = 16;

  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam logic [7:0] MASK_RESET   = 8'hFE;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_HEADER_BYTE   = 1'b0,
    CFG_CHECKSUM_MASK = 1'b1
  } cfg_idx_e;

  // scanner sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HDR0,
    ST_HDR1,
    ST_LEN,
    ST_ID,
    ST_CMD,
    ST_CK1,
    ST_CK2,
    ST_XSUM,
    ST_CMP,
    ST_EMIT,
    ST_EMIT0,
    ST_FINISH
  } scan_state_e;

  // one decoded result
  typedef struct packed {
    logic [7:0]       servo_id;
    logic [7:0]       command;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic [IDX_W-1:0] payload_count;
    logic             last;
    logic [ERR_W-1:0] error_count;
  } result_t;

  // configuration seen by the scanner
  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] checksum_mask;
  } cfg_t;

endpackage

// ===== design/spd_rx_fifo.sv =====
// two-entry byte queue between the receive side and the scanner
// depends on spd_pkg
`timescale 1ns / 1ps

module spd_rx_fifo
  import spd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] data_o
);

  logic [7:0] slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/spd_scanner.sv =====
// back end: byte window memory, packet hunt sequencer and result register
// depends on spd_pkg
`timescale 1ns / 1ps

module spd_scanner
  import spd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_valid_i,
  input  logic [7:0] q_data_i,
  output logic       q_pop_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  localparam logic [SUM_W-1:0] OVH = SUM_W'(FRAME_OVERHEAD);
  localparam logic [SUM_W-1:0] WIN = SUM_W'(WINDOW_BYTES);

  scan_state_e       state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] pos_q, pos_d;
  logic [7:0]        k_q, k_d;
  logic [7:0]        len_q, len_d;
  logic [7:0]        id_q, id_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        c1_q, c1_d;
  logic [7:0]        c2_q, c2_d;
  logic [7:0]        x_q, x_d;
  logic [ERR_W-1:0]  err_q, err_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;

  logic [7:0]        mem [WINDOW_BYTES];
  logic [7:0]        rd_data_q;
  logic              rd_en, wr_en;
  logic [SUM_W-1:0]  rd_off;
  logic [PTR_W-1:0]  rd_addr, wr_addr;

  logic [SUM_W-1:0]  pos_ext, fill_ext, len_ext, k_ext;
  logic [7:0]        npay, k_inc;
  logic              can_load;
  logic [ERR_W-1:0]  err_inc;

  assign pos_ext  = SUM_W'(pos_q);
  assign fill_ext = SUM_W'(fill_q);
  assign len_ext  = SUM_W'(len_q);
  assign k_ext    = SUM_W'(k_q);
  assign npay     = len_q - 8'(FRAME_OVERHEAD);
  assign k_inc    = k_q + 8'd1;
  assign can_load = !out_valid_q || res_ready_i;
  assign err_inc  = (err_q == {ERR_W{1'b1}}) ? err_q : err_q + ERR_W'(1);
  assign rd_addr  = head_q + rd_off[PTR_W-1:0];
  assign wr_addr  = head_q + fill_q[PTR_W-1:0];

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    k_d         = k_q;
    len_d       = len_q;
    id_d        = id_q;
    cmd_d       = cmd_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    x_d         = x_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !res_ready_i;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_off      = '0;
    wr_en       = 1'b0;
    q_pop_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          // append byte, dropping the oldest one when full
          q_pop_o = 1'b1;
          wr_en   = 1'b1;
          pos_d   = '0;
          if (fill_ext == WIN) begin
            head_d = head_q + PTR_W'(1);
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pos_ext + OVH > fill_ext) begin
          state_d = ST_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_off  = pos_ext;
          state_d = ST_HDR0;
        end
      end
      ST_HDR0: begin
        if (rd_data_q != cfg_i.header_byte) begin
          pos_d   = pos_q + FILL_W'(1);
          state_d = ST_SCAN;
        end else begin
          rd_en   = 1'b1;
          rd_off  = pos_ext + SUM_W'(1);
          state_d = ST_HDR1;
        end
      end
      ST_HDR1: begin
        if (rd_data_q != cfg_i.header_byte) begin
          pos_d   = pos_q + FILL_W'(1);
          state_d = ST_SCAN;
        end else begin
          rd_en   = 1'b1;
          rd_off  = pos_ext + SUM_W'(2);
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        len_d = rd_data_q;
        if (SUM_W'(rd_data_q) < OVH || SUM_W'(rd_data_q) > WIN) begin
          // bad length counts as a failure
          err_d   = err_inc;
          pos_d   = pos_q + FILL_W'(1);
          state_d = ST_SCAN;
        end else if (pos_ext + SUM_W'(rd_data_q) > fill_ext) begin
          // packet not complete yet
          state_d = ST_FINISH;
        end else begin
          rd_en   = 1'b1;
          rd_off  = pos_ext + SUM_W'(3);
          state_d = ST_ID;
        end
      end
      ST_ID: begin
        id_d    = rd_data_q;
        rd_en   = 1'b1;
        rd_off  = pos_ext + SUM_W'(4);
        state_d = ST_CMD;
      end
      ST_CMD: begin
        cmd_d   = rd_data_q;
        x_d     = len_q ^ id_q ^ rd_data_q;
        rd_en   = 1'b1;
        rd_off  = pos_ext + SUM_W'(5);
        state_d = ST_CK1;
      end
      ST_CK1: begin
        c1_d    = rd_data_q;
        rd_en   = 1'b1;
        rd_off  = pos_ext + SUM_W'(6);
        state_d = ST_CK2;
      end
      ST_CK2: begin
        c2_d = rd_data_q;
        k_d  = 8'(FRAME_OVERHEAD);
        if (OVH < len_ext) begin
          rd_en   = 1'b1;
          rd_off  = pos_ext + OVH;
          state_d = ST_XSUM;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_XSUM: begin
        // fold one payload byte per cycle
        x_d = x_q ^ rd_data_q;
        k_d = k_inc;
        if (k_inc < len_q) begin
          rd_en  = 1'b1;
          rd_off = pos_ext + SUM_W'(k_inc);
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (c1_q != (x_q & cfg_i.checksum_mask) ||
            c2_q != (~x_q & cfg_i.checksum_mask)) begin
          err_d   = err_inc;
          pos_d   = pos_q + FILL_W'(1);
          state_d = ST_SCAN;
        end else if (npay == 8'd0) begin
          state_d = ST_EMIT0;
        end else begin
          k_d     = 8'd0;
          rd_en   = 1'b1;
          rd_off  = pos_ext + OVH;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        rd_en = 1'b1;
        if (can_load) begin
          out_valid_d         = 1'b1;
          res_d.servo_id      = id_q;
          res_d.command       = cmd_q;
          res_d.payload_byte  = rd_data_q;
          res_d.payload_index = k_q[IDX_W-1:0];
          res_d.payload_count = npay[IDX_W-1:0];
          res_d.last          = (k_inc == npay);
          res_d.error_count   = err_q;
          k_d                 = k_inc;
          rd_off              = pos_ext + OVH + SUM_W'(k_inc);
          if (k_inc == npay) begin
            rd_en   = 1'b0;
            pos_d   = FILL_W'(pos_ext + len_ext);
            state_d = ST_FINISH;
          end
        end else begin
          // hold the read until the result register frees up
          rd_off = pos_ext + OVH + k_ext;
        end
      end
      ST_EMIT0: begin
        if (can_load) begin
          out_valid_d         = 1'b1;
          res_d.servo_id      = id_q;
          res_d.command       = cmd_q;
          res_d.payload_byte  = 8'd0;
          res_d.payload_index = '0;
          res_d.payload_count = '0;
          res_d.last          = 1'b1;
          res_d.error_count   = err_q;
          pos_d               = FILL_W'(pos_ext + len_ext);
          state_d             = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // discard consumed bytes
        if (pos_q >= fill_q) begin
          fill_d = '0;
        end else begin
          head_d = head_q + pos_q[PTR_W-1:0];
          fill_d = fill_q - pos_q;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // packet fields and result payload
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    id_q  <= id_d;
    cmd_q <= cmd_d;
    c1_q  <= c1_d;
    c2_q  <= c2_d;
    x_q   <= x_d;
    res_q <= res_d;
  end

  // window memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= q_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

// ===== design/servo_packet_deframer.sv =====
// Servo packet deframer. Received bytes pass a two-entry queue into a
// 64-byte circular window held in a single-port-read memory; after each byte
// the scanner walks the window through that read port hunting for the
// two header bytes, checks length and both checksums, and emits one result
// per payload byte (a single result for an empty payload) through a result
// register. The scanner takes no new byte from the queue until its rescan
// of the window is done. Depends on spd_pkg, spd_rx_fifo and spd_scanner.
`timescale 1ns / 1ps

module servo_packet_deframer
  import spd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        servo_id_o,
  output logic [7:0]        command_o,
  output logic [7:0]        payload_byte_o,
  output logic [IDX_W-1:0]  payload_index_o,
  output logic [IDX_W-1:0]  payload_count_o,
  output logic              last_o,
  output logic [ERR_W-1:0]  error_count_o
);

  cfg_t       cfg_q;
  logic       q_full, q_valid, q_pop;
  logic [7:0] q_data;
  result_t    res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte   <= HEADER_RESET;
      cfg_q.checksum_mask <= MASK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER_BYTE:   cfg_q.header_byte   <= cfg_data_i;
        CFG_CHECKSUM_MASK: cfg_q.checksum_mask <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: receive queue
  assign rx_ready_o = !q_full;

  spd_rx_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (rx_valid_i),
    .push_data_i (rx_byte_i),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // back: window scanner
  spd_scanner u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign servo_id_o      = res.servo_id;
  assign command_o       = res.command;
  assign payload_byte_o  = res.payload_byte;
  assign payload_index_o = res.payload_index;
  assign payload_count_o = res.payload_count;
  assign last_o          = res.last;
  assign error_count_o   = res.error_count;

endmodule

// ===== design/spd_checker.sv =====
// port-level checks on the result channel of the servo packet deframer
// depends on spd_pkg and servo_packet_deframer_assert.svh
`timescale 1ns / 1ps
`include "servo_packet_deframer_assert.svh"

module spd_checker
  import spd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [7:0]       payload_byte_o,
  input logic [IDX_W-1:0] payload_index_o,
  input logic [IDX_W-1:0] payload_count_o,
  input logic             last_o
);

  `SPD_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(payload_byte_o))
  `SPD_ASSERT_IMPLY(a_index, out_valid_o && payload_count_o != '0, payload_index_o < payload_count_o)
  `SPD_ASSERT_IMPLY(a_last, out_valid_o && payload_count_o != '0, last_o == (IDX_W'(payload_index_o + IDX_W'(1)) == payload_count_o))
  `SPD_ASSERT_IMPLY(a_empty, out_valid_o && payload_count_o == '0, last_o && payload_byte_o == 8'd0 && payload_index_o == '0)

endmodule

bind servo_packet_deframer spd_checker u_spd_checker (.*);

// ===== dv/tb_servo_packet_deframer.sv =====
// self-checking testbench for servo_packet_deframer: directed and random byte streams,
// a scoreboard class predicts the decoded results; depends on spd_pkg and the design
`timescale 1ns / 1ps

module tb_servo_packet_deframer;
  import spd_pkg::*;

  // decoded-packet scoreboard with its own copy of the deframing state
  class packet_scoreboard;
    logic [7:0]  win[WINDOW_BYTES];
    int          fill;
    logic [15:0] fails;
    logic [7:0]  hdr;
    logic [7:0]  mask;
    result_t     pending[$];
    int          mismatches;
    int          bytes_seen;
    int          results_seen;

    function new();
      fill = 0;
      fails = '0;
      hdr = HEADER_RESET;
      mask = MASK_RESET;
      mismatches = 0;
      bytes_seen = 0;
      results_seen = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [7:0] val);
      if (idx == CFG_HEADER_BYTE) hdr = val;
      else mask = val;
    endfunction

    // accepted rx transaction: append, rescan, queue the packet it completes
    function void note_byte(logic [7:0] b);
      int      pos;
      int      len;
      int      npay;
      logic [7:0] x;
      result_t r;
      result_t found[$];
      bytes_seen++;
      if (fill >= WINDOW_BYTES) begin
        for (int i = 0; i < WINDOW_BYTES - 1; i++) win[i] = win[i+1];
        fill = WINDOW_BYTES - 1;
      end
      win[fill] = b;
      fill++;
      pos = 0;
      while (pos + FRAME_OVERHEAD <= fill) begin
        if (win[pos] != hdr || win[pos+1] != hdr) begin
          pos++;
          continue;
        end
        len = win[pos+2];
        if (len < FRAME_OVERHEAD || len > WINDOW_BYTES) begin
          if (fails != 16'hFFFF) fails++;
          pos++;
          continue;
        end
        if (pos + len > fill) break;
        x = 8'(len) ^ win[pos+3] ^ win[pos+4];
        for (int k = FRAME_OVERHEAD; k < len; k++) x ^= win[pos+k];
        if (win[pos+5] != (x & mask) || win[pos+6] != (~x & mask)) begin
          if (fails != 16'hFFFF) fails++;
          pos++;
          continue;
        end
        npay = len - FRAME_OVERHEAD;
        r = '0;
        r.servo_id = win[pos+3];
        r.command = win[pos+4];
        if (npay == 0) begin
          r.last = 1'b1;
          found.push_back(r);
        end else begin
          for (int k = 0; k < npay; k++) begin
            r.payload_byte = win[pos+FRAME_OVERHEAD+k];
            r.payload_index = IDX_W'(k);
            r.payload_count = IDX_W'(npay);
            r.last = (k + 1 == npay);
            found.push_back(r);
          end
        end
        pos += len;
        break;
      end
      // drop consumed bytes
      if (pos >= fill) begin
        fill = 0;
      end else if (pos > 0) begin
        for (int i = 0; i < fill - pos; i++) win[i] = win[i+pos];
        fill -= pos;
      end
      foreach (found[i]) begin
        found[i].error_count = fails;
        pending.push_back(found[i]);
      end
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] exp);
      $display("mismatch on %s: got %0h, expected %0h", what, got, exp);
      mismatches++;
    endtask

    // accepted result transaction against the oldest expectation
    task check_result(result_t got);
      result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        report("unexpected result", got.servo_id, 16'h0);
        return;
      end
      exp = pending.pop_front();
      if (got.servo_id != exp.servo_id) report("servo_id", got.servo_id, exp.servo_id);
      if (got.command != exp.command) report("command", got.command, exp.command);
      if (got.payload_byte != exp.payload_byte)
        report("payload_byte", got.payload_byte, exp.payload_byte);
      if (got.payload_index != exp.payload_index)
        report("payload_index", got.payload_index, exp.payload_index);
      if (got.payload_count != exp.payload_count)
        report("payload_count", got.payload_count, exp.payload_count);
      if (got.last != exp.last) report("last", got.last, exp.last);
      if (got.error_count != exp.error_count)
        report("error_count", got.error_count, exp.error_count);
    endtask
  endclass

  localparam int DRAIN_CYCLES = 4000;
  localparam int STALL_LIMIT  = 20000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              rx_valid_i = 1'b0;
  logic              rx_ready_o;
  logic [7:0]        rx_byte_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_index_i = '0;
  logic [7:0]        cfg_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [7:0]        servo_id_o;
  logic [7:0]        command_o;
  logic [7:0]        payload_byte_o;
  logic [IDX_W-1:0]  payload_index_o;
  logic [IDX_W-1:0]  payload_count_o;
  logic              last_o;
  logic [ERR_W-1:0]  error_count_o;

  packet_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  servo_packet_deframer u_top (.*);

  always #5 clk_i = ~clk_i;

  // sink side: random backpressure bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.servo_id = servo_id_o;
      got.command = command_o;
      got.payload_byte = payload_byte_o;
      got.payload_index = payload_index_o;
      got.payload_count = payload_count_o;
      got.last = last_o;
      got.error_count = error_count_o;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task send_byte(logic [7:0] b);
    int n;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_valid_i = 1'b0;
      n = $urandom_range(1, 17);
      repeat (n) @(negedge clk_i);
    end
    rx_valid_i = 1'b1;
    rx_byte_i = b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    sb.note_byte(b);
    @(negedge clk_i);
  endtask

  // well-formed packet, optionally with one byte flipped
  task send_packet(int npay, bit corrupt);
    logic [7:0] pkt[$];
    logic [7:0] x;
    int len;
    int at;
    len = npay + FRAME_OVERHEAD;
    pkt = '{sb.hdr, sb.hdr, 8'(len), 8'($urandom), 8'($urandom), 8'h00, 8'h00};
    for (int i = 0; i < npay; i++) pkt.push_back(8'($urandom));
    x = pkt[2] ^ pkt[3] ^ pkt[4];
    for (int i = FRAME_OVERHEAD; i < len; i++) x ^= pkt[i];
    pkt[5] = x & sb.mask;
    pkt[6] = ~x & sb.mask;
    if (corrupt) begin
      at = $urandom_range(0, len - 1);
      pkt[at] = pkt[at] ^ (8'h01 << $urandom_range(0, 7));
    end
    foreach (pkt[i]) send_byte(pkt[i]);
  endtask

  // stop sending, let the expected results drain and the scanner settle
  task wait_idle();
    rx_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task write_cfg(cfg_idx_e idx, logic [7:0] val);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_cfg(idx, val);
  endtask

  // random mix: mostly good packets, some corrupted, bad lengths and noise
  task random_phase(int nbytes);
    int stop_at;
    int pick;
    stop_at = sb.bytes_seen + nbytes;
    while (sb.bytes_seen < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_packet(($urandom_range(0, 19) == 0) ? 57 : $urandom_range(0, 8), 1'b0);
      end else if (pick < 80) begin
        send_packet($urandom_range(0, 6), 1'b1);
      end else if (pick < 88) begin
        send_byte(sb.hdr);
        send_byte(sb.hdr);
        send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(65, 255)));
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        // long noise run overflows the window
        repeat (70) send_byte(($urandom_range(0, 3) == 0) ? sb.hdr : 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty payload, extreme bytes, bad lengths, checksum failure
    send_packet(0, 1'b0);
    send_byte(sb.hdr); send_byte(sb.hdr); send_byte(8'd6);
    send_byte(sb.hdr); send_byte(sb.hdr); send_byte(8'd65);
    send_packet(1, 1'b0);
    send_byte(sb.hdr); send_byte(sb.hdr); send_byte(8'd7); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h00); send_byte(8'hFF);

    random_phase(80);
    write_cfg(CFG_HEADER_BYTE, 8'h00);
    write_cfg(CFG_CHECKSUM_MASK, 8'hFF);
    random_phase(80);
    write_cfg(CFG_HEADER_BYTE, 8'hA5);
    write_cfg(CFG_CHECKSUM_MASK, 8'h00);
    random_phase(80);
    write_cfg(CFG_HEADER_BYTE, 8'hFF);
    write_cfg(CFG_CHECKSUM_MASK, 8'hFE);
    random_phase(40);
    gaps_on = 1'b0;
    random_phase(50);

    wait_idle();
    $display("covered %0d rx bytes and %0d decoded results over four header/mask settings",
             sb.bytes_seen, sb.results_seen);
    $display("predicted failure count at end: %0d", sb.fails);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
